// ===== hdl/sacs_pkg.sv =====
// Package for the sensor address change sequencer.
// Holds the phase, status and request codes, the field widths and the small helper functions.
// No dependencies.
package sacs_pkg;

    localparam int SCAN_SLOTS_DEF = 16;

    localparam int ADDR_W  = 8;
    localparam int TIMER_W = 20;
    localparam int EL_W    = 16;

    localparam logic [ADDR_W-1:0]  ADDR_BASE   = 8'hE0;
    localparam logic [TIMER_W-1:0] TIMER_MAX   = 20'hFFFFF;
    localparam logic [ADDR_W-1:0]  OLD_ADDR_RST = 8'd224;
    localparam logic [ADDR_W-1:0]  NEW_ADDR_RST = 8'd226;
    localparam logic [TIMER_W-1:0] PAUSE_RST   = 20'd50000;

    localparam logic [7:0] RX_EMPTY = 8'h00;
    localparam logic [7:0] RX_FLOAT = 8'hFF;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_OLD_ADDR = 2'd0;
    localparam logic [1:0] REG_NEW_ADDR = 2'd1;
    localparam logic [1:0] REG_PAUSE    = 2'd2;

    // Item codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    localparam logic [1:0] BUS_PENDING = 2'd0;
    localparam logic [1:0] BUS_DONE    = 2'd1;
    localparam logic [1:0] BUS_ERROR   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PENDING = 3'd1,
        PH_PINGING = 3'd2,
        PH_CHANGE  = 3'd3,
        PH_AFTER   = 3'd4,
        PH_SUCCESS = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RUNNING  = 3'd1,
        ST_SUCCESS  = 3'd2,
        ST_BADPARAM = 3'd3,
        ST_BUSERR   = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_TOOMANY  = 3'd6,
        ST_MISSING  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        RQ_NONE    = 2'd0,
        RQ_PING    = 2'd1,
        RQ_WRITE   = 2'd2,
        RQ_RELEASE = 2'd3
    } t_request;

    // A usable sensor address is even and lies in the top block of the bus.
    function automatic logic addr_ok(input logic [ADDR_W-1:0] a);
        return (a >= ADDR_BASE) && !a[0];
    endfunction

    // The unlock bytes, then the new address, then zero to mark the end.
    function automatic logic [7:0] seq_byte(input logic [2:0] idx,
                                            input logic [ADDR_W-1:0] new_addr);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'hA0;
            3'd1:    b = 8'hAA;
            3'd2:    b = 8'hA5;
            3'd3:    b = new_addr;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic ping_found(input logic [1:0] bs, input logic [7:0] rx);
        return (bs == BUS_DONE) && (rx != RX_EMPTY) && (rx != RX_FLOAT);
    endfunction

endpackage

// ===== hdl/sacs_poll_if.sv =====
// Channel that carries start and poll items into the sequencer.
// Plain valid/ready handshake; no dependencies.
interface sacs_poll_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        enqueue_ok;
    logic [1:0]  bus_state;
    logic [7:0]  rx_byte;
    logic [15:0] elapsed_us;

    modport source (output valid, op, enqueue_ok, bus_state, rx_byte, elapsed_us,
                    input ready);
    modport sink   (input valid, op, enqueue_ok, bus_state, rx_byte, elapsed_us,
                    output ready);
endinterface

// ===== hdl/sacs_result_if.sv =====
// Channel that carries the status and bus request for each item out of the sequencer.
// Plain valid/ready handshake; no dependencies.
interface sacs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] request;
    logic [7:0] target_address;
    logic [7:0] write_byte;

    modport source (output valid, status, request, target_address, write_byte,
                    input ready);
    modport sink   (input valid, status, request, target_address, write_byte,
                    output ready);
endinterface

// ===== hdl/sensor_address_change_sequencer.sv =====
// Top level of the sensor address change sequencer.
// Uses sacs_pkg and the interfaces sacs_poll_if and sacs_result_if.
//
//  channel    dir  handshake          payload
//  i_poll     in   valid/ready        op, enqueue_ok, bus_state, rx_byte, elapsed_us
//  o_result   out  valid/ready        status, request, target_address, write_byte
//  APB        in   psel/penable/pready old_address, new_address, pause_us at 0x0/0x4/0x8
//
// Each item is decided in the cycle it is accepted and its result appears in the
// output register in the next cycle, so one item per cycle is sustained while o_result is ready.
// The output register alone sets the rate: a new item is taken whenever that
// register is empty or is being emptied in the same cycle.
// Reset (synchronous, active low) returns the sequencer to idle and the
// configuration registers to their default values.
module sensor_address_change_sequencer #(
    parameter int SCAN_SLOTS = sacs_pkg::SCAN_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sacs_poll_if.sink           i_poll,
    sacs_result_if.source       o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SLOT_W = $clog2(SCAN_SLOTS + 1);

    // Configuration registers.
    logic [sacs_pkg::ADDR_W-1:0]  r_old_addr;
    logic [sacs_pkg::ADDR_W-1:0]  r_new_addr;
    logic [sacs_pkg::TIMER_W-1:0] r_pause_us;

    // Sequencer state.
    sacs_pkg::t_phase             r_phase, n_phase;
    logic [SLOT_W-1:0]            r_scan_slot, n_scan_slot;
    logic                         r_ping_waiting, n_ping_waiting;
    logic [SCAN_SLOTS-1:0]        r_found_map, n_found_map;
    logic [2:0]                   r_seq_idx, n_seq_idx;
    logic [sacs_pkg::TIMER_W-1:0] r_pause_timer, n_pause_timer;
    logic                         r_pause_running, n_pause_running;

    // Result register.
    logic                         r_out_valid;
    sacs_pkg::t_status            r_status, n_status;
    sacs_pkg::t_request           r_request, n_request;
    logic [7:0]                   r_target, n_target;
    logic [7:0]                   r_wbyte, n_wbyte;

    // Shared decisions.
    logic                         w_accept;
    logic                         w_poll;
    logic                         w_params_bad;
    logic                         w_slot_active;
    logic [7:0]                   w_slot_addr;
    logic                         w_found;
    logic                         w_scan_release;
    logic [SCAN_SLOTS-1:0]        w_map_upd;
    logic [SLOT_W-1:0]            w_slot_upd;
    logic                         w_scan_end;
    logic                         w_old_found;
    logic                         w_too_many;
    logic [7:0]                   w_seq_byte;
    logic [sacs_pkg::TIMER_W:0]   w_timer_sum;
    logic [sacs_pkg::TIMER_W-1:0] w_timer_sat;
    logic                         w_pause_done;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_addr <= sacs_pkg::OLD_ADDR_RST;
            r_new_addr <= sacs_pkg::NEW_ADDR_RST;
            r_pause_us <= sacs_pkg::PAUSE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                sacs_pkg::REG_OLD_ADDR: r_old_addr <= pwdata[7:0];
                sacs_pkg::REG_NEW_ADDR: r_new_addr <= pwdata[7:0];
                sacs_pkg::REG_PAUSE:    r_pause_us <= pwdata[sacs_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sacs_pkg::REG_OLD_ADDR: prdata = 32'(r_old_addr);
            sacs_pkg::REG_NEW_ADDR: prdata = 32'(r_new_addr);
            sacs_pkg::REG_PAUSE:    prdata = 32'(r_pause_us);
            default:                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign i_poll.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_poll.valid && i_poll.ready;
    assign w_poll       = (i_poll.op == sacs_pkg::OP_POLL);

    // ------------------------------------------------------------------
    // Shared decisions
    // ------------------------------------------------------------------
    always_comb begin
        w_params_bad = (r_old_addr == r_new_addr) || !sacs_pkg::addr_ok(r_old_addr)
                       || !sacs_pkg::addr_ok(r_new_addr);

        w_slot_active = (r_scan_slot < SLOT_W'(SCAN_SLOTS));
        w_slot_addr   = sacs_pkg::ADDR_BASE + 8'({r_scan_slot, 1'b0});
        w_found       = sacs_pkg::ping_found(i_poll.bus_state, i_poll.rx_byte);

        w_scan_release = w_slot_active && r_ping_waiting && i_poll.enqueue_ok
                         && (i_poll.bus_state != sacs_pkg::BUS_PENDING);

        w_map_upd = r_found_map;
        for (int i = 0; i < SCAN_SLOTS; i++) begin
            if (w_scan_release && w_found && (r_scan_slot == SLOT_W'(i))) begin
                w_map_upd[i] = 1'b1;
            end
        end
        w_slot_upd = w_scan_release ? r_scan_slot + SLOT_W'(1) : r_scan_slot;
        w_scan_end = (w_slot_upd >= SLOT_W'(SCAN_SLOTS));

        // The old address sits at slot (old - 0xE0) / 2 when it is usable at all.
        w_old_found = 1'b0;
        for (int i = 0; i < SCAN_SLOTS; i++) begin
            if (sacs_pkg::addr_ok(r_old_addr) && (r_old_addr[4:1] == 4'(i))
                && w_map_upd[i]) begin
                w_old_found = 1'b1;
            end
        end
        // More than one bit set exactly when clearing the lowest one leaves some.
        w_too_many = |(w_map_upd & (w_map_upd - SCAN_SLOTS'(1)));

        w_seq_byte = sacs_pkg::seq_byte(r_seq_idx, r_new_addr);

        w_timer_sum  = {1'b0, r_pause_timer} + (sacs_pkg::TIMER_W + 1)'(i_poll.elapsed_us);
        w_timer_sat  = w_timer_sum[sacs_pkg::TIMER_W] ? sacs_pkg::TIMER_MAX
                                                      : w_timer_sum[sacs_pkg::TIMER_W-1:0];
        w_pause_done = (w_timer_sat >= r_pause_us);
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_phase         = r_phase;
        n_scan_slot     = r_scan_slot;
        n_ping_waiting  = r_ping_waiting;
        n_found_map     = r_found_map;
        n_seq_idx       = r_seq_idx;
        n_pause_timer   = r_pause_timer;
        n_pause_running = r_pause_running;

        if (w_accept) begin
            if (!w_poll) begin
                n_phase = sacs_pkg::PH_PENDING;
            end else begin
                unique case (r_phase)
                    sacs_pkg::PH_PENDING: begin
                        if (w_params_bad) begin
                            n_phase = sacs_pkg::PH_ERROR;
                        end else begin
                            n_found_map    = '0;
                            n_ping_waiting = 1'b0;
                            n_scan_slot    = '0;
                            n_phase        = sacs_pkg::PH_PINGING;
                        end
                    end
                    sacs_pkg::PH_PINGING: begin
                        if (w_slot_active) begin
                            if (!r_ping_waiting) begin
                                n_ping_waiting = 1'b1;
                            end else if (!i_poll.enqueue_ok || w_scan_release) begin
                                n_ping_waiting = 1'b0;
                            end
                        end
                        n_found_map = w_map_upd;
                        n_scan_slot = w_slot_upd;
                        if (w_scan_end) begin
                            if (!w_old_found || w_too_many) begin
                                n_phase = sacs_pkg::PH_ERROR;
                            end else begin
                                n_phase         = sacs_pkg::PH_CHANGE;
                                n_seq_idx       = '0;
                                n_pause_timer   = '0;
                                n_pause_running = 1'b0;
                            end
                        end
                    end
                    sacs_pkg::PH_CHANGE: begin
                        if (!r_pause_running) begin
                            if (w_seq_byte != 8'h00) begin
                                n_pause_running = 1'b1;
                                n_pause_timer   = '0;
                            end else begin
                                n_ping_waiting = 1'b0;
                                n_phase        = sacs_pkg::PH_AFTER;
                            end
                        end else if (!i_poll.enqueue_ok) begin
                            n_phase = sacs_pkg::PH_ERROR;
                        end else begin
                            n_pause_timer = w_timer_sat;
                            if (w_pause_done) begin
                                if (i_poll.bus_state[1]) begin
                                    n_phase = sacs_pkg::PH_ERROR;
                                end else if (i_poll.bus_state == sacs_pkg::BUS_DONE) begin
                                    n_pause_running = 1'b0;
                                    n_pause_timer   = '0;
                                    n_seq_idx       = r_seq_idx + 3'd1;
                                end
                            end
                        end
                    end
                    sacs_pkg::PH_AFTER: begin
                        if (!r_ping_waiting) begin
                            n_ping_waiting = 1'b1;
                        end else if (!i_poll.enqueue_ok) begin
                            n_ping_waiting = 1'b0;
                            n_phase        = sacs_pkg::PH_ERROR;
                        end else if (i_poll.bus_state != sacs_pkg::BUS_PENDING) begin
                            n_ping_waiting = 1'b0;
                            n_phase = w_found ? sacs_pkg::PH_SUCCESS : sacs_pkg::PH_ERROR;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result of the item
    // ------------------------------------------------------------------
    always_comb begin
        n_status  = sacs_pkg::ST_IDLE;
        n_request = sacs_pkg::RQ_NONE;
        n_target  = '0;
        n_wbyte   = '0;

        if (!w_poll) begin
            n_status = sacs_pkg::ST_RUNNING;
        end else begin
            unique case (r_phase)
                sacs_pkg::PH_PENDING: begin
                    n_status = w_params_bad ? sacs_pkg::ST_BADPARAM : sacs_pkg::ST_RUNNING;
                end
                sacs_pkg::PH_PINGING: begin
                    n_status = sacs_pkg::ST_RUNNING;
                    if (w_slot_active) begin
                        if (!r_ping_waiting) begin
                            n_request = sacs_pkg::RQ_PING;
                            n_target  = w_slot_addr;
                        end else if (!i_poll.enqueue_ok) begin
                            n_status = sacs_pkg::ST_BUSERR;
                        end else if (w_scan_release) begin
                            n_request = sacs_pkg::RQ_RELEASE;
                            n_target  = w_slot_addr;
                        end
                    end
                    if (w_scan_end) begin
                        if (!w_old_found) begin
                            n_status = sacs_pkg::ST_NOTFOUND;
                        end else if (w_too_many) begin
                            n_status = sacs_pkg::ST_TOOMANY;
                        end
                    end
                end
                sacs_pkg::PH_CHANGE: begin
                    n_status = sacs_pkg::ST_RUNNING;
                    if (!r_pause_running) begin
                        n_target = r_old_addr;
                        if (w_seq_byte != 8'h00) begin
                            n_request = sacs_pkg::RQ_WRITE;
                            n_wbyte   = w_seq_byte;
                        end else begin
                            n_request = sacs_pkg::RQ_RELEASE;
                        end
                    end else if (!i_poll.enqueue_ok
                                 || (w_pause_done && i_poll.bus_state[1])) begin
                        n_request = sacs_pkg::RQ_RELEASE;
                        n_target  = r_old_addr;
                        n_status  = sacs_pkg::ST_BUSERR;
                    end
                end
                sacs_pkg::PH_AFTER: begin
                    n_status = sacs_pkg::ST_RUNNING;
                    if (!r_ping_waiting) begin
                        n_request = sacs_pkg::RQ_PING;
                        n_target  = r_new_addr;
                    end else if (!i_poll.enqueue_ok) begin
                        n_status = sacs_pkg::ST_BUSERR;
                    end else if (i_poll.bus_state != sacs_pkg::BUS_PENDING) begin
                        n_request = sacs_pkg::RQ_RELEASE;
                        n_target  = r_new_addr;
                        n_status  = w_found ? sacs_pkg::ST_SUCCESS : sacs_pkg::ST_MISSING;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= sacs_pkg::PH_IDLE;
            r_scan_slot     <= '0;
            r_ping_waiting  <= 1'b0;
            r_found_map     <= '0;
            r_seq_idx       <= '0;
            r_pause_timer   <= '0;
            r_pause_running <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_scan_slot     <= n_scan_slot;
            r_ping_waiting  <= n_ping_waiting;
            r_found_map     <= n_found_map;
            r_seq_idx       <= n_seq_idx;
            r_pause_timer   <= n_pause_timer;
            r_pause_running <= n_pause_running;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_request <= n_request;
            r_target  <= n_target;
            r_wbyte   <= n_wbyte;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_status;
    assign o_result.request        = r_request;
    assign o_result.target_address = r_target;
    assign o_result.write_byte     = r_wbyte;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_poll |=> r_phase == sacs_pkg::PH_PENDING)
        else $error("start item did not arm the sequencer");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sacs_pkg::PH_PINGING |-> r_scan_slot < SLOT_W'(SCAN_SLOTS))
        else $error("scan slot beyond the last slot while pinging");

    a_no_target_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_request == sacs_pkg::RQ_NONE |-> r_target == 8'h00)
        else $error("target address given without a request");

    a_wbyte_only_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_request != sacs_pkg::RQ_WRITE |-> r_wbyte == 8'h00)
        else $error("write byte given without a write request");

    a_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sacs_pkg::PH_CHANGE && !r_pause_running |-> r_pause_timer == '0)
        else $error("pause timer running between writes");

endmodule
